### src/skce_pkg.sv
// Shared types and constants for the sortable key column encoder.
`default_nettype none

package skce_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // Column types of a fixed request.
  localparam logic [3:0] COL_BOOL     = 4'd0;
  localparam logic [3:0] COL_I8       = 4'd1;
  localparam logic [3:0] COL_U8       = 4'd2;
  localparam logic [3:0] COL_I16      = 4'd3;
  localparam logic [3:0] COL_U16      = 4'd4;
  localparam logic [3:0] COL_I32      = 4'd5;
  localparam logic [3:0] COL_U32      = 4'd6;
  localparam logic [3:0] COL_I64      = 4'd7;
  localparam logic [3:0] COL_U64      = 4'd8;
  localparam logic [3:0] COL_FLOAT    = 4'd9;
  localparam logic [3:0] COL_DOUBLE   = 4'd10;
  localparam logic [3:0] COL_STRING   = 4'd11;
  localparam logic [3:0] COL_I128     = 4'd12;
  localparam logic [3:0] COL_U128     = 4'd13;
  localparam logic [3:0] COL_INTERVAL = 4'd14;

  // Sign masks and marker bytes.
  localparam logic [7:0]  SIGN8      = 8'h80;
  localparam logic [15:0] SIGN16     = 16'h8000;
  localparam logic [31:0] SIGN32     = 32'h8000_0000;
  localparam logic [63:0] SIGN64     = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  BYTE_NULL  = 8'h00;
  localparam logic [7:0]  BYTE_VALID = 8'h01;
  localparam logic [7:0]  BYTE_ESC   = 8'hFF;

  // Encoded key buffer: up to 17 bytes per request, first byte on top.
  localparam int KEY_BYTES = 17;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int KEY_CNT_W = $clog2(KEY_BYTES + 1);

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         col_type;
    logic               is_null;
    logic [63:0]        value_high;
    logic [63:0]        value_low;
    logic signed [31:0] months;
    logic signed [31:0] days;
    logic signed [63:0] micros;
    logic [7:0]         data_byte;
  } skce_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } skce_key_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key_bytes;
    logic [KEY_CNT_W-1:0] count;
  } skce_entry_t;

endpackage

`default_nettype wire

### src/skce_front.sv
// Front part: registers a request and builds its complete encoded key.
`default_nettype none

module skce_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  skce_pkg::skce_req_t     req_data,
  output logic                    push_valid,
  input  logic                    push_ready,
  output skce_pkg::skce_entry_t   push_data
);
  import skce_pkg::*;

  logic        stg_valid;
  skce_req_t   stg;
  logic [4:0]  stg_msb;
  logic [4:0]  msb_next;

  logic        skip;
  logic        drain;

  logic [31:0] f_bits;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [52:0] sub_shift;
  logic [10:0] sub_exp;
  logic [10:0] norm_exp;
  logic [63:0] dbl_bits;
  logic [63:0] dbl_src;
  logic [63:0] dbl_sort;

  // Position of the top set bit of a float mantissa, for subnormal widening.
  always_comb begin
    msb_next = '0;
    for (int i = 0; i < 23; i++) begin
      if (req_data.value_high[i]) begin
        msb_next = 5'(i);
      end
    end
  end

  // A null string data or end request produces no byte.
  assign skip       = stg.is_null && ((stg.kind == KIND_DATA) || (stg.kind == KIND_END));
  assign push_valid = stg_valid && !skip;
  assign drain      = stg_valid && (skip || push_ready);
  assign req_ready  = !stg_valid || drain;

  // Stage register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req_ready) begin
      stg_valid <= req_valid;
    end
  end

  // Stage register payload.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stg     <= req_data;
      stg_msb <= msb_next;
    end
  end

  // Exact float to double widening.
  assign f_bits    = stg.value_high[31:0];
  assign f_exp     = f_bits[30:23];
  assign f_man     = f_bits[22:0];
  assign sub_shift = {30'b0, f_man} << (6'd52 - {1'b0, stg_msb});
  assign sub_exp   = 11'(stg_msb) + 11'd874;
  assign norm_exp  = {3'b0, f_exp} + 11'd896;

  always_comb begin
    if (f_exp == 8'hFF) begin
      if (f_man == '0) begin
        dbl_bits = {f_bits[31], 11'h7FF, 52'b0};
      end else begin
        dbl_bits = {f_bits[31], 11'h7FF, 1'b1, f_man[21:0], 29'b0};
      end
    end else if (f_exp == 8'h00) begin
      if (f_man == '0) begin
        dbl_bits = {f_bits[31], 63'b0};
      end else begin
        dbl_bits = {f_bits[31], sub_exp, sub_shift[51:0]};
      end
    end else begin
      dbl_bits = {f_bits[31], norm_exp, f_man, 29'b0};
    end
  end

  // Order-preserving double transform, shared by float and double columns.
  assign dbl_src  = (stg.col_type == COL_FLOAT) ? dbl_bits : stg.value_high;
  assign dbl_sort = dbl_src[63] ? ~dbl_src : (dbl_src ^ SIGN64);

  // Build the key bytes, left aligned, and their count.
  always_comb begin
    push_data.key_bytes = '0;
    push_data.count     = KEY_CNT_W'(1);
    case (stg.kind)
      KIND_FIXED: begin
        if (stg.is_null) begin
          push_data.key_bytes = {BYTE_NULL, 128'b0};
          push_data.count     = KEY_CNT_W'(1);
        end else begin
          case (stg.col_type)
            COL_BOOL: begin
              push_data.key_bytes = {BYTE_VALID, 7'b0, (stg.value_high != '0), 120'b0};
              push_data.count     = KEY_CNT_W'(2);
            end
            COL_I8: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[7:0] ^ SIGN8, 120'b0};
              push_data.count     = KEY_CNT_W'(2);
            end
            COL_U8: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[7:0], 120'b0};
              push_data.count     = KEY_CNT_W'(2);
            end
            COL_I16: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[15:0] ^ SIGN16, 112'b0};
              push_data.count     = KEY_CNT_W'(3);
            end
            COL_U16: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[15:0], 112'b0};
              push_data.count     = KEY_CNT_W'(3);
            end
            COL_I32: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[31:0] ^ SIGN32, 96'b0};
              push_data.count     = KEY_CNT_W'(5);
            end
            COL_U32: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high[31:0], 96'b0};
              push_data.count     = KEY_CNT_W'(5);
            end
            COL_I64: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high ^ SIGN64, 64'b0};
              push_data.count     = KEY_CNT_W'(9);
            end
            COL_U64: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high, 64'b0};
              push_data.count     = KEY_CNT_W'(9);
            end
            COL_FLOAT, COL_DOUBLE: begin
              push_data.key_bytes = {BYTE_VALID, dbl_sort, 64'b0};
              push_data.count     = KEY_CNT_W'(9);
            end
            COL_STRING: begin
              push_data.key_bytes = {BYTE_VALID, BYTE_NULL, BYTE_NULL, 112'b0};
              push_data.count     = KEY_CNT_W'(3);
            end
            COL_I128: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high ^ SIGN64, stg.value_low};
              push_data.count     = KEY_CNT_W'(17);
            end
            COL_U128: begin
              push_data.key_bytes = {BYTE_VALID, stg.value_high, stg.value_low};
              push_data.count     = KEY_CNT_W'(17);
            end
            COL_INTERVAL: begin
              push_data.key_bytes = {BYTE_VALID, stg.months ^ SIGN32, stg.days ^ SIGN32,
                                     stg.micros ^ SIGN64};
              push_data.count     = KEY_CNT_W'(17);
            end
            default: begin
              // An unused column type gives the prefix byte alone.
              push_data.key_bytes = {BYTE_VALID, 128'b0};
              push_data.count     = KEY_CNT_W'(1);
            end
          endcase
        end
      end
      KIND_BEGIN: begin
        push_data.key_bytes = {(stg.is_null ? BYTE_NULL : BYTE_VALID), 128'b0};
        push_data.count     = KEY_CNT_W'(1);
      end
      KIND_DATA: begin
        // A zero byte is escaped as 00 FF.
        push_data.key_bytes = {stg.data_byte, BYTE_ESC, 120'b0};
        push_data.count     = (stg.data_byte == '0) ? KEY_CNT_W'(2) : KEY_CNT_W'(1);
      end
      KIND_END: begin
        push_data.key_bytes = {BYTE_NULL, BYTE_NULL, 120'b0};
        push_data.count     = KEY_CNT_W'(2);
      end
      default: begin
        push_data.key_bytes = '0;
        push_data.count     = KEY_CNT_W'(1);
      end
    endcase
  end

endmodule

`default_nettype wire

### src/skce_queue.sv
// Short queue of encoded keys between the front and back parts.
`default_nettype none

module skce_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  skce_pkg::skce_entry_t  push_data,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output skce_pkg::skce_entry_t  pop_data
);
  import skce_pkg::*;

  skce_entry_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  fill;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (fill != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/skce_back.sv
// Back part: shifts out an encoded key one byte per cycle into the output register, while the output is not stalled.
`default_nettype none

module skce_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  skce_pkg::skce_entry_t  pop_data,
  output logic                   key_valid,
  input  logic                   key_ready,
  output skce_pkg::skce_key_t    key_data
);
  import skce_pkg::*;

  logic [KEY_W-1:0]     shift;
  logic [KEY_CNT_W-1:0] remain;
  logic                 advance;
  logic                 do_pop;

  // The output register can take a byte when empty or being drained.
  assign advance   = !key_valid || key_ready;
  assign pop_ready = (remain == '0) || (advance && (remain == KEY_CNT_W'(1)));
  assign do_pop    = pop_valid && pop_ready;

  // Control: output valid and remaining byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      remain    <= '0;
    end else begin
      if (advance) begin
        key_valid <= (remain != '0);
      end
      if (do_pop) begin
        remain <= pop_data.count;
      end else if (advance && (remain != '0)) begin
        remain <= remain - 1'b1;
      end
    end
  end

  // Payload: byte shift register and output register.
  always_ff @(posedge clk) begin
    if (advance && (remain != '0)) begin
      key_data.out_byte <= shift[KEY_W-1 -: 8];
      key_data.last     <= (remain == KEY_CNT_W'(1));
    end
    if (do_pop) begin
      shift <= pop_data.key_bytes;
    end else if (advance && (remain != '0)) begin
      shift <= shift << 8;
    end
  end

endmodule

`default_nettype wire

### src/sortable_key_column_encoder.sv
// A request's key goes through the front stage register, a queue slot and the back shift
// register before its first byte reaches the output register. Throughput: one key byte per
// cycle while the output is not stalled, set by the single byte-wide output register of the
// back part; a key has 1 to 17 bytes, and a request that yields no byte never enters the queue.
// Reset is synchronous and active high; it empties the stage, the queue and the output.
`default_nettype none

module sortable_key_column_encoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  skce_pkg::skce_req_t  req_data,
  output logic                 key_valid,
  input  logic                 key_ready,
  output skce_pkg::skce_key_t  key_data
);
  import skce_pkg::*;

  logic        push_valid;
  logic        push_ready;
  skce_entry_t push_data;
  logic        pop_valid;
  logic        pop_ready;
  skce_entry_t pop_data;

  // Front part: classify the request and build its key.
  skce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue between the two parts.
  skce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back part: serialize the key bytes.
  skce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key_data  (key_data)
  );

endmodule

`default_nettype wire

### src/skce_checker.sv
// Port-level checker for the sortable key column encoder, with its bind.
`default_nettype none

module skce_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input skce_pkg::skce_req_t  req_data,
  input logic                 key_valid,
  input logic                 key_ready,
  input skce_pkg::skce_key_t  key_data
);
  import skce_pkg::*;

  // A stalled request holds its payload until it is accepted.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("stalled request changed");

  // A stalled output byte holds.
  assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_ready |=> key_valid && $stable(key_data))
    else $error("stalled key byte changed");

  // The output is empty right after reset.
  assert property (@(posedge clk) rst |=> !key_valid)
    else $error("key valid after reset");

  // Bytes of one key follow without a gap.
  assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready && !key_data.last |=> key_valid)
    else $error("gap inside a key");

  // The input only stalls while output bytes are pending.
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> key_valid)
    else $error("request stalled with idle output");

endmodule

bind sortable_key_column_encoder skce_checker u_skce_checker (.*);

`default_nettype wire

### bench/sortable_key_column_encoder_test.sv
// Self-checking testbench for the sortable key column encoder: directed and random requests.
module sortable_key_column_encoder_test;
  import skce_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 8;
  localparam int SHOWN_ERRORS = 10;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  skce_req_t req_data;
  logic key_valid;
  logic key_ready;
  skce_key_t key_data;

  // Bytes still owed by the block, oldest first.
  skce_key_t expected_keys[$];
  int unsigned failures = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit idle_on = 1'b1;
  bit hold_keys = 1'b0;

  sortable_key_column_encoder i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .key_valid(key_valid),
    .key_ready(key_ready),
    .key_data(key_data)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact widening of single precision bits to double precision bits.
  function automatic logic [63:0] widen_single(input logic [31:0] f);
    logic [7:0] e;
    logic [22:0] m;
    logic [51:0] frac;
    int p;
    e = f[30:23];
    m = f[22:0];
    if (e == 8'hFF) begin
      // Infinity stays infinity; a NaN keeps its payload and becomes quiet.
      if (m == '0) return {f[31], 11'h7FF, 52'd0};
      frac = {m, 29'd0};
      frac[51] = 1'b1;
      return {f[31], 11'h7FF, frac};
    end
    if (e == 8'h00) begin
      if (m == '0) return {f[31], 63'd0};
      // Normalize a subnormal: the leading one sets the exponent.
      p = 22;
      while (!m[p]) p--;
      frac = 52'(m);
      frac[p] = 1'b0;
      frac = frac << (52 - p);
      return {f[31], 11'(p + 874), frac};
    end
    return {f[31], 11'(e) + 11'd896, m, 29'd0};
  endfunction

  // Byte-comparable form of a double.
  function automatic logic [63:0] order_double(input logic [63:0] u);
    return u[63] ? ~u : (u ^ SIGN64);
  endfunction

  function automatic void put_be(ref logic [7:0] bytes[$], input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bytes = {bytes, v[8*i +: 8]};
  endfunction

  // Works out the key bytes of one request and queues them with the last mark.
  function automatic void encode_column(input skce_req_t r);
    logic [7:0] bytes[$];
    skce_key_t k;
    case (r.kind)
      KIND_FIXED: begin
        if (r.is_null) begin
          bytes = {bytes, BYTE_NULL};
        end else begin
          bytes = {bytes, BYTE_VALID};
          case (r.col_type)
            COL_BOOL: bytes = {bytes, ((r.value_high != '0) ? 8'h01 : 8'h00)};
            COL_I8: bytes = {bytes, (r.value_high[7:0] ^ SIGN8)};
            COL_U8: bytes = {bytes, r.value_high[7:0]};
            COL_I16: put_be(bytes, 64'(r.value_high[15:0] ^ SIGN16), 2);
            COL_U16: put_be(bytes, 64'(r.value_high[15:0]), 2);
            COL_I32: put_be(bytes, 64'(r.value_high[31:0] ^ SIGN32), 4);
            COL_U32: put_be(bytes, 64'(r.value_high[31:0]), 4);
            COL_I64: put_be(bytes, r.value_high ^ SIGN64, 8);
            COL_U64: put_be(bytes, r.value_high, 8);
            COL_FLOAT: put_be(bytes, order_double(widen_single(r.value_high[31:0])), 8);
            COL_DOUBLE: put_be(bytes, order_double(r.value_high), 8);
            COL_STRING: begin
              // An empty string: just the terminator.
              bytes = {bytes, BYTE_NULL};
              bytes = {bytes, BYTE_NULL};
            end
            COL_I128: begin
              put_be(bytes, r.value_high ^ SIGN64, 8);
              put_be(bytes, r.value_low, 8);
            end
            COL_U128: begin
              put_be(bytes, r.value_high, 8);
              put_be(bytes, r.value_low, 8);
            end
            COL_INTERVAL: begin
              put_be(bytes, 64'(r.months ^ SIGN32), 4);
              put_be(bytes, 64'(r.days ^ SIGN32), 4);
              put_be(bytes, r.micros ^ SIGN64, 8);
            end
            default: ;
          endcase
        end
      end
      KIND_BEGIN: bytes = {bytes, (r.is_null ? BYTE_NULL : BYTE_VALID)};
      KIND_DATA: begin
        // A zero byte is escaped so it sorts above the terminator.
        if (!r.is_null) begin
          bytes = {bytes, r.data_byte};
          if (r.data_byte == 8'h00) bytes = {bytes, BYTE_ESC};
        end
      end
      default: begin
        if (!r.is_null) begin
          bytes = {bytes, BYTE_NULL};
          bytes = {bytes, BYTE_NULL};
        end
      end
    endcase
    foreach (bytes[i]) begin
      k.out_byte = bytes[i];
      k.last = (i == bytes.size() - 1);
      expected_keys = {expected_keys, k};
    end
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= SHOWN_ERRORS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Random value of the given width, biased toward zero, all ones and the sign boundary.
  function automatic logic [63:0] rand_word(input int w);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = mask;
      2: v = 64'd1 << (w - 1);
      3: v = mask >> 1;
      4: v = 64'($urandom_range(0, 255));
      default: v = {$urandom, $urandom};
    endcase
    // Narrow types ignore the upper bits, so fill them at times.
    if ($urandom_range(0, 1)) v = v & mask;
    else v = v | ({$urandom, $urandom} & ~mask);
    return v;
  endfunction

  // Single precision bits with zero, special and random exponents.
  function automatic logic [31:0] rand_single();
    logic [7:0] e;
    logic [22:0] m;
    case ($urandom_range(0, 3))
      0: e = 8'h00;
      1: e = 8'hFF;
      default: e = 8'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: m = '0;
      1: m = 23'd1 << $urandom_range(0, 22);
      default: m = 23'($urandom);
    endcase
    return {1'($urandom), e, m};
  endfunction

  function automatic logic [7:0] rand_data_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Every field random; callers then shape the fields that matter.
  function automatic skce_req_t random_fields();
    skce_req_t r;
    r.kind = 2'($urandom);
    r.col_type = 4'($urandom);
    r.is_null = 1'($urandom);
    r.value_high = {$urandom, $urandom};
    r.value_low = {$urandom, $urandom};
    r.months = $urandom;
    r.days = $urandom;
    r.micros = {$urandom, $urandom};
    r.data_byte = 8'($urandom);
    return r;
  endfunction

  function automatic skce_req_t random_fixed();
    skce_req_t r;
    r = random_fields();
    r.kind = KIND_FIXED;
    r.col_type = 4'($urandom_range(0, 15));
    r.is_null = ($urandom_range(0, 9) == 0);
    r.value_high = rand_word(8 << $urandom_range(0, 3));
    r.value_low = rand_word(64);
    r.months = 32'(rand_word(32));
    r.days = 32'(rand_word(32));
    r.micros = rand_word(64);
    if (r.col_type == COL_FLOAT) r.value_high[31:0] = rand_single();
    if (r.col_type == COL_BOOL && $urandom_range(0, 1)) r.value_high = '0;
    return r;
  endfunction

  function automatic skce_req_t fixed_request(input logic [3:0] col, input logic [63:0] vh,
                                              input logic [63:0] vl);
    skce_req_t r;
    r = '0;
    r.kind = KIND_FIXED;
    r.col_type = col;
    r.value_high = vh;
    r.value_low = vl;
    return r;
  endfunction

  function automatic skce_req_t string_request(input logic [1:0] kind, input logic is_null,
                                               input logic [7:0] b);
    skce_req_t r;
    r = random_fields();
    r.kind = kind;
    r.is_null = is_null;
    r.data_byte = b;
    return r;
  endfunction

  // Offers one request, waits for the handshake and queues its key bytes.
  task automatic send_request(input skce_req_t r);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 6) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    encode_column(r);
    items_sent++;
  endtask

  // Stops offering requests until every expected byte has come out.
  task automatic drain_keys();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // A begin, some data bytes and an end; now and then a data byte with the wrong null flag.
  task automatic send_string();
    logic null_str;
    int n;
    null_str = ($urandom_range(0, 5) == 0);
    n = $urandom_range(0, 6);
    send_request(string_request(KIND_BEGIN, null_str, 8'($urandom)));
    repeat (n) begin
      send_request(string_request(KIND_DATA, ($urandom_range(0, 9) == 0) ? !null_str : null_str,
                                  rand_data_byte()));
    end
    send_request(string_request(KIND_END, null_str, 8'($urandom)));
  endtask

  // Mostly columns and well-formed strings, with some stray requests.
  task automatic send_random_until(input int unsigned target);
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_request(random_fields());
        1, 2, 3: send_string();
        default: send_request(random_fixed());
      endcase
    end
  endtask

  task automatic test_fixed_columns();
    skce_req_t r;
    // Every column type with all-ones values and extreme interval parts.
    for (int t = 0; t < 16; t++) begin
      r = fixed_request(4'(t), '1, '1);
      r.months = 32'sh8000_0000;
      r.days = 32'sh7FFF_FFFF;
      r.micros = SIGN64;
      send_request(r);
    end
    send_request(fixed_request(COL_BOOL, '0, '1));
    r = fixed_request(COL_INTERVAL, '0, '0);
    r.months = 32'sh7FFF_FFFF;
    r.days = 32'sh8000_0000;
    r.micros = ~SIGN64;
    send_request(r);
    send_request(fixed_request(COL_I128, SIGN64, '0));
    // A null column gives a lone zero byte.
    r = fixed_request(COL_I128, '1, '1);
    r.is_null = 1'b1;
    send_request(r);
    // Negative subnormal float of smallest magnitude.
    send_request(fixed_request(COL_FLOAT, 64'h8000_0001, '0));
  endtask

  task automatic test_string_items();
    send_request(string_request(KIND_BEGIN, 1'b0, 8'h00));
    send_request(string_request(KIND_DATA, 1'b0, 8'h00));
    send_request(string_request(KIND_END, 1'b0, 8'hFF));
    // A null string: the begin byte alone, data and end give nothing.
    send_request(string_request(KIND_BEGIN, 1'b1, 8'hFF));
    send_request(string_request(KIND_DATA, 1'b1, 8'h00));
    send_request(string_request(KIND_END, 1'b1, 8'h00));
    drain_keys();
  endtask

  task automatic test_random_mix();
    idle_on = 1'b1;
    send_random_until(items_sent + 110);
    drain_keys();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_random_until(items_sent + 30);
    idle_on = 1'b1;
  endtask

  // The output stalls for a long stretch while wide columns keep coming.
  task automatic test_output_stall();
    hold_keys = 1'b1;
    repeat (12) send_request(fixed_request(COL_U128, {$urandom, $urandom}, {$urandom, $urandom}));
    drain_keys();
  endtask

  // Key output ready: random stalls, or a long hold-off when requested.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      key_ready <= 1'b0;
    end else if (hold_keys) begin
      hold_keys = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      key_ready <= 1'b0;
    end else begin
      key_ready <= !(idle_on && $urandom_range(0, 99) < 6);
    end
  end

  // Compare every accepted key byte with the oldest expected one.
  always @(posedge clk) begin : key_check
    skce_key_t want;
    if (!rst && key_valid && key_ready) begin
      if (expected_keys.size() == 0) begin
        note_failure($sformatf("unexpected key byte %h last %b", key_data.out_byte,
                               key_data.last));
      end else begin
        want = expected_keys.pop_front();
        if (key_data.out_byte !== want.out_byte || key_data.last !== want.last)
          note_failure($sformatf("key byte expected %h last %b, got %h last %b",
                                 want.out_byte, want.last, key_data.out_byte, key_data.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sortable_key_column_encoder verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    key_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fixed_columns();
    test_string_items();
    test_random_mix();
    test_back_to_back();
    test_output_stall();
    drain_keys();

    if (failures == 0 && expected_keys.size() == 0) begin
      $display("sortable_key_column_encoder verification clean");
    end else begin
      $display("sortable_key_column_encoder verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/skce_pkg.sv
src/skce_front.sv
src/skce_queue.sv
src/skce_back.sv
src/sortable_key_column_encoder.sv
src/skce_checker.sv
bench/sortable_key_column_encoder_test.sv
